>>> rtl/assert_macros.svh
// Assertion macros shared by the option header parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("property violated");
// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

>>> rtl/ipv6opt_pkg.sv
// Shared types and constants for the IPv6 option header parser.
`default_nettype none
package ipv6opt_pkg;

    // Result status codes.
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;
    localparam logic [1:0] ST_SHORT   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_SEARCH_MODE = 1'b0;
    localparam logic CFG_WANTED_TYPE = 1'b1;

    // Default depth of the queue between the parser and the emitter.
    localparam int QUEUE_DEPTH = 4;

    // One parsed byte's outcome: an optional report and an optional terminal word.
    typedef struct packed {
        logic        rep;
        logic [7:0]  typ;
        logic [8:0]  len;
        logic [10:0] off;
        logic        term;
        logic [1:0]  term_st;
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/ipv6opt_front.sv
// Byte-level walker of the options header that classifies each byte into a command.
`default_nettype none
`include "assert_macros.svh"
module ipv6opt_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_index,
    input  wire [7:0]          i_cfg_wdata,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire [7:0]          i_data_byte,
    input  wire                i_end_of_buffer,
    input  wire                i_queue_full,
    output logic               o_push,
    output ipv6opt_pkg::t_cmd  o_cmd
);
    // Walk phases.
    localparam logic [2:0] PH_NXT  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_OLEN = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    logic        r_search_mode;
    logic [7:0]  r_wanted_type;
    logic [2:0]  r_phase,  n_phase;
    logic [10:0] r_offset, n_offset;
    logic [7:0]  r_units,  n_units;
    logic [7:0]  r_cur,    n_cur;
    logic [10:0] r_start,  n_start;
    logic [7:0]  r_rem,    n_rem;

    logic        w_accept;
    logic [11:0] w_hlen;
    logic [11:0] w_units1;
    logic [11:0] w_pos;
    logic [11:0] w_pos1;
    logic        w_fin;
    logic [7:0]  w_ftype;
    logic [10:0] w_fstart;
    logic [11:0] w_total;
    logic        w_hit;
    ipv6opt_pkg::t_cmd w_cmd;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;

    // Header length in bytes is (units + 1) * 8.
    assign w_units1 = {4'b0, r_units} + 12'd1;
    assign w_hlen   = {w_units1[8:0], 3'b000};
    assign w_pos    = {1'b0, r_offset};
    assign w_pos1   = w_pos + 12'd1;

    // Next-state and command decode for the current byte.
    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset;
        n_units  = r_units;
        n_cur    = r_cur;
        n_start  = r_start;
        n_rem    = r_rem;
        w_fin    = 1'b0;
        w_ftype  = r_cur;
        w_fstart = r_start;
        w_total  = '0;
        w_hit    = 1'b0;
        w_cmd    = '0;

        unique case (r_phase)
            PH_NXT: begin
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                n_units = i_data_byte;
                n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                n_start = r_offset;
                n_cur   = i_data_byte;
                if (i_data_byte == 8'd0) begin
                    w_fin    = 1'b1;
                    w_ftype  = i_data_byte;
                    w_fstart = r_offset;
                end else if (w_pos + 12'd2 > w_hlen) begin
                    w_cmd.term    = 1'b1;
                    w_cmd.term_st = ipv6opt_pkg::ST_OVERRUN;
                    n_phase       = PH_DONE;
                end else begin
                    n_phase = PH_OLEN;
                end
            end
            PH_OLEN: begin
                if ({1'b0, r_start} + {4'b0, i_data_byte} + 12'd2 > w_hlen) begin
                    w_cmd.term    = 1'b1;
                    w_cmd.term_st = ipv6opt_pkg::ST_OVERRUN;
                    n_phase       = PH_DONE;
                end else if (i_data_byte == 8'd0) begin
                    w_fin = 1'b1;
                end else begin
                    n_rem   = i_data_byte;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_rem = r_rem - 8'd1;
                if (n_rem == 8'd0) begin
                    w_fin = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // Option completed on this byte: report it if it qualifies.
        if (w_fin) begin
            w_total   = w_pos1 - {1'b0, w_fstart};
            w_hit     = r_search_mode ? (w_ftype == r_wanted_type) : (w_ftype > 8'd1);
            w_cmd.rep = w_hit;
            w_cmd.typ = w_ftype;
            w_cmd.len = w_total[8:0];
            w_cmd.off = w_fstart;
            if (w_pos1 == w_hlen) begin
                w_cmd.term    = 1'b1;
                w_cmd.term_st = ipv6opt_pkg::ST_END;
                n_phase       = PH_DONE;
            end else begin
                n_phase = PH_TYPE;
            end
        end

        if (n_phase != PH_DONE) begin
            n_offset = r_offset + 11'd1;
        end

        // End of buffer: flag a short buffer if the walk is still open, then restart.
        if (i_end_of_buffer) begin
            if (n_phase != PH_DONE) begin
                w_cmd.term    = 1'b1;
                w_cmd.term_st = ipv6opt_pkg::ST_SHORT;
            end
            n_phase  = PH_NXT;
            n_offset = '0;
            n_units  = '0;
            n_cur    = '0;
            n_start  = '0;
            n_rem    = '0;
        end
    end

    assign o_push = w_accept && (w_cmd.rep || w_cmd.term);
    assign o_cmd  = w_cmd;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_mode <= 1'b0;
            r_wanted_type <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ipv6opt_pkg::CFG_SEARCH_MODE: r_search_mode <= i_cfg_wdata[0];
                ipv6opt_pkg::CFG_WANTED_TYPE: r_wanted_type <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Walk state, advanced once per accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_NXT;
            r_offset <= '0;
            r_units  <= '0;
            r_cur    <= '0;
            r_start  <= '0;
            r_rem    <= '0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_units  <= n_units;
            r_cur    <= n_cur;
            r_start  <= n_start;
            r_rem    <= n_rem;
        end
    end

    // An overrun can only come from a type or length byte.
    `ASSERT_CLK(a_overrun_src, i_clk, i_rst_n, (o_push && o_cmd.term && (o_cmd.term_st == ipv6opt_pkg::ST_OVERRUN)) |-> ((r_phase == PH_TYPE) || (r_phase == PH_OLEN)))
    // A reported option always has a nonzero length.
    `ASSERT_CLK(a_rep_len, i_clk, i_rst_n, (o_push && o_cmd.rep) |-> (o_cmd.len != 9'd0))
    // Nothing is pushed while the queue is full.
    `ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, o_push && i_queue_full)

endmodule
`default_nettype wire

>>> rtl/ipv6opt_queue.sv
// Small command queue that decouples the byte walker from the result emitter.
`default_nettype none
`include "assert_macros.svh"
module ipv6opt_queue #(
    parameter int DEPTH = ipv6opt_pkg::QUEUE_DEPTH
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  ipv6opt_pkg::t_cmd  i_cmd,
    output logic               o_full,
    input  wire                i_pop,
    output logic               o_head_valid,
    output ipv6opt_pkg::t_cmd  o_head
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ipv6opt_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Never read from an empty queue.
    `ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && !o_head_valid)

endmodule
`default_nettype wire

>>> rtl/ipv6opt_back.sv
// Result emitter that turns queued commands into one or two output words.
`default_nettype none
`include "assert_macros.svh"
module ipv6opt_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_head_valid,
    input  ipv6opt_pkg::t_cmd  i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [1:0]         o_status,
    output logic [7:0]         o_option_type,
    output logic [8:0]         o_option_length,
    output logic [10:0]        o_option_offset,
    output logic               o_final_result
);
    logic        r_valid;
    logic        r_half;
    logic        n_half;
    logic [1:0]  r_status,  n_status;
    logic [7:0]  r_type,    n_type;
    logic [8:0]  r_length,  n_length;
    logic [10:0] r_offset,  n_offset;
    logic        r_final,   n_final;
    logic        w_load;

    // Output register takes a new word whenever it is empty or being drained.
    assign w_load = i_head_valid && (!r_valid || i_ready);

    // Pick the report first, then the terminal word of the same command.
    always_comb begin
        n_half   = r_half;
        n_status = ipv6opt_pkg::ST_FOUND;
        n_type   = '0;
        n_length = '0;
        n_offset = '0;
        n_final  = 1'b0;
        o_pop    = 1'b0;
        if (i_head.rep && !r_half) begin
            n_type   = i_head.typ;
            n_length = i_head.len;
            n_offset = i_head.off;
            if (i_head.term) begin
                n_half = 1'b1;
            end else begin
                o_pop = w_load;
            end
        end else begin
            n_status = i_head.term_st;
            n_final  = 1'b1;
            n_half   = 1'b0;
            o_pop    = w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_half  <= n_half;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= n_status;
            r_type   <= n_type;
            r_length <= n_length;
            r_offset <= n_offset;
            r_final  <= n_final;
        end
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_option_type   = r_type;
    assign o_option_length = r_length;
    assign o_option_offset = r_offset;
    assign o_final_result  = r_final;

    // Mid-command only while a report-plus-terminal command sits at the head.
    `ASSERT_CLK(a_half_head, i_clk, i_rst_n, r_half |-> (i_head_valid && i_head.rep && i_head.term))

endmodule
`default_nettype wire

>>> rtl/ipv6_option_header_parser_top.sv
// Top level of the IPv6 hop-by-hop / destination options header parser.
// Input channel: one header byte per word (i_data_byte, i_end_of_buffer) on
// i_valid / o_ready. Output channel: result words (status, option type,
// length, offset, final flag) on o_valid / i_ready.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 search mode, 1 wanted type) at the clock edge; write only while idle.
// A byte is walked in the cycle it is accepted, so bytes stream at one per
// cycle while the queue is not full. A byte that yields results places one
// command in a queue of QUEUE_DEPTH entries; the emitter drains it at one
// result word per cycle while the receiver is ready, so a byte with two
// results uses two output words. A result is stored in the queue and then in
// the output register, and the second result of a byte follows the first.
// When the receiver stalls, the output word holds, the queue fills, and
// o_ready drops once the queue is full.
// Reset (synchronous, i_rst_n low) clears the walk, the queue, the output
// valid flag and both configuration registers.
`default_nettype none
module ipv6_option_header_parser_top #(
    parameter int QUEUE_DEPTH = ipv6opt_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire [7:0]   i_cfg_wdata,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [7:0]   i_data_byte,
    input  wire         i_end_of_buffer,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_option_type,
    output logic [8:0]  o_option_length,
    output logic [10:0] o_option_offset,
    output logic        o_final_result
);
    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_head_valid;
    ipv6opt_pkg::t_cmd w_cmd;
    ipv6opt_pkg::t_cmd w_head;

    // Byte walker.
    ipv6opt_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_queue_full    (w_full),
        .o_push          (w_push),
        .o_cmd           (w_cmd)
    );

    // Command queue.
    ipv6opt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_cmd),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // Result emitter.
    ipv6opt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_option_type   (o_option_type),
        .o_option_length (o_option_length),
        .o_option_offset (o_option_offset),
        .o_final_result  (o_final_result)
    );

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the IPv6 option header parser top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;

    // Walk phases of the option header, as tracked by the predictor.
    typedef enum logic [2:0] {
        PH_NEXT_HDR,
        PH_HDR_LEN,
        PH_OPT_TYPE,
        PH_OPT_LEN,
        PH_OPT_DATA,
        PH_WALK_DONE
    } t_walk_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_hdr_byte;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  opt_type;
        logic [8:0]  opt_len;
        logic [10:0] opt_off;
        logic        fin;
    } t_option_report;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic        i_cfg_index     = 1'b0;
    logic [7:0]  i_cfg_wdata     = 8'd0;
    logic        i_valid         = 1'b0;
    logic [7:0]  i_data_byte     = 8'd0;
    logic        i_end_of_buffer = 1'b0;
    logic        i_ready         = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_option_type;
    logic [8:0]  o_option_length;
    logic [10:0] o_option_offset;
    logic        o_final_result;

    t_hdr_byte      header_bytes_q[$];
    t_option_report pending_reports_q[$];
    int             queued_items = 0;
    int             fault_count  = 0;
    bit             calm_run     = 1'b0;

    // Predictor copy of the configuration and of the walk state.
    logic        cfg_find_mode   = 1'b0;
    logic [7:0]  cfg_wanted_type = 8'd0;
    t_walk_phase walk_phase      = PH_NEXT_HDR;
    logic [10:0] walk_offset     = 11'd0;
    logic [7:0]  walk_units      = 8'd0;
    logic [7:0]  walk_cur_type   = 8'd0;
    logic [10:0] walk_opt_start  = 11'd0;
    logic [7:0]  walk_data_left  = 8'd0;
    logic        walk_hdr_done   = 1'b0;

    ipv6_option_header_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_option_type   (o_option_type),
        .o_option_length (o_option_length),
        .o_option_offset (o_option_offset),
        .o_final_result  (o_final_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void push_report(input logic [1:0] st, input logic [7:0] ty,
                                        input logic [8:0] ln, input logic [10:0] off,
                                        input logic fin);
        t_option_report rep;
        rep = '{status: st, opt_type: ty, opt_len: ln, opt_off: off, fin: fin};
        pending_reports_q.push_back(rep);
    endfunction

    // The current option ends on the byte at pos: report it if it qualifies.
    function automatic void close_option(input int pos, input int hlen);
        int   total;
        logic hit;
        total = pos + 1 - int'(walk_opt_start);
        hit = cfg_find_mode ? (walk_cur_type == cfg_wanted_type) : (walk_cur_type > 8'd1);
        if (hit) begin
            push_report(ipv6opt_pkg::ST_FOUND, walk_cur_type, total[8:0], walk_opt_start,
                        1'b0);
        end
        if (pos + 1 == hlen) begin
            push_report(ipv6opt_pkg::ST_END, 8'd0, 9'd0, 11'd0, 1'b1);
            walk_phase    = PH_WALK_DONE;
            walk_hdr_done = 1'b1;
        end else begin
            walk_phase = PH_OPT_TYPE;
        end
    endfunction

    // Advance the walk by one accepted byte and queue the results it causes.
    function automatic void walk_option_byte(input logic [7:0] b, input logic eob);
        int pos;
        int hlen;
        pos  = int'(walk_offset);
        hlen = (int'(walk_units) + 1) * 8;
        case (walk_phase)
            PH_NEXT_HDR: begin
                walk_phase = PH_HDR_LEN;
            end
            PH_HDR_LEN: begin
                walk_units = b;
                walk_phase = PH_OPT_TYPE;
            end
            PH_OPT_TYPE: begin
                walk_opt_start = pos[10:0];
                walk_cur_type  = b;
                if (b == 8'd0) begin
                    close_option(pos, hlen);
                end else if (pos + 2 > hlen) begin
                    push_report(ipv6opt_pkg::ST_OVERRUN, 8'd0, 9'd0, 11'd0, 1'b1);
                    walk_phase    = PH_WALK_DONE;
                    walk_hdr_done = 1'b1;
                end else begin
                    walk_phase = PH_OPT_LEN;
                end
            end
            PH_OPT_LEN: begin
                if (int'(walk_opt_start) + int'(b) + 2 > hlen) begin
                    push_report(ipv6opt_pkg::ST_OVERRUN, 8'd0, 9'd0, 11'd0, 1'b1);
                    walk_phase    = PH_WALK_DONE;
                    walk_hdr_done = 1'b1;
                end else if (b == 8'd0) begin
                    close_option(pos, hlen);
                end else begin
                    walk_data_left = b;
                    walk_phase     = PH_OPT_DATA;
                end
            end
            PH_OPT_DATA: begin
                walk_data_left = walk_data_left - 8'd1;
                if (walk_data_left == 8'd0) begin
                    close_option(pos, hlen);
                end
            end
            default: begin
            end
        endcase
        if (walk_phase != PH_WALK_DONE) begin
            walk_offset = 11'(pos + 1);
        end
        // The buffer ends here: flag a short buffer if the walk is still open, then start a new header.
        if (eob) begin
            if (walk_phase != PH_WALK_DONE && !walk_hdr_done) begin
                push_report(ipv6opt_pkg::ST_SHORT, 8'd0, 9'd0, 11'd0, 1'b1);
            end
            walk_phase     = PH_NEXT_HDR;
            walk_offset    = 11'd0;
            walk_units     = 8'd0;
            walk_cur_type  = 8'd0;
            walk_opt_start = 11'd0;
            walk_data_left = 8'd0;
            walk_hdr_done  = 1'b0;
        end
    endfunction

    // Gap lengths: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 60);
    endfunction

    function automatic void queue_byte(input logic [7:0] data, input logic last);
        t_hdr_byte item;
        item = '{data: data, last: last};
        header_bytes_q.push_back(item);
        queued_items++;
    endfunction

    // Build one options header with random options; damage it on request by
    // corrupting a byte, adding trailing bytes, cutting it short or replacing it
    // with noise.
    task automatic queue_header(input int units, input int max_len, input bit allow_damage);
        logic [7:0] hdr[$];
        logic [7:0] typ;
        int         hlen;
        int         pos;
        int         rem;
        int         lim;
        int         olen;
        int         r;
        int         kind;
        int         cut;
        hlen = (units + 1) * 8;
        hdr.push_back(8'($urandom_range(0, 255)));
        hdr.push_back(units[7:0]);
        pos = 2;
        while (pos < hlen) begin
            rem = hlen - pos;
            r = $urandom_range(0, 99);
            if (rem == 1 || r < 15) begin
                typ = 8'd0;
            end else if (r < 30) begin
                typ = 8'd1;
            end else if (r < 55) begin
                typ = cfg_wanted_type;
            end else if (r < 65) begin
                typ = 8'hFF;
            end else begin
                typ = 8'($urandom_range(2, 255));
            end
            if (typ == 8'd0) begin
                hdr.push_back(typ);
                pos++;
            end else begin
                lim = rem - 2;
                if (lim > max_len) lim = max_len;
                olen = $urandom_range(0, lim);
                hdr.push_back(typ);
                hdr.push_back(olen[7:0]);
                repeat (olen) hdr.push_back(8'($urandom_range(0, 255)));
                pos += olen + 2;
            end
        end
        kind = allow_damage ? $urandom_range(0, 99) : 0;
        if (kind >= 92) begin
            // Noise: random bytes with random buffer ends.
            cut = $urandom_range(1, 12);
            for (int i = 0; i < cut; i++) begin
                queue_byte(8'($urandom_range(0, 255)),
                           (i == cut - 1) || ($urandom_range(0, 3) == 0));
            end
        end else begin
            if (kind >= 60 && kind < 72) begin
                hdr[$urandom_range(1, hdr.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (kind >= 72 && kind < 82) begin
                repeat ($urandom_range(1, 5)) hdr.push_back(8'($urandom_range(0, 255)));
            end else if (kind >= 82) begin
                cut = $urandom_range(1, hdr.size() - 1);
                while (hdr.size() > cut) void'(hdr.pop_back());
            end
            foreach (hdr[i]) begin
                queue_byte(hdr[i], i == hdr.size() - 1);
            end
        end
    endtask

    // Wait until every word is sent and every expected result has arrived,
    // then let the pipeline settle.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (header_bytes_q.size() != 0 || i_valid || pending_reports_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        if (idx == ipv6opt_pkg::CFG_SEARCH_MODE) begin
            cfg_find_mode = val[0];
        end else begin
            cfg_wanted_type = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One phase of random headers; a long header, when asked for, counts
    // toward the phase's word budget.
    task automatic run_phase(input logic mode, input logic [7:0] want, input bit calm,
                             input int n_items, input bit with_big);
        int start;
        int r;
        int units;
        write_cfg(ipv6opt_pkg::CFG_SEARCH_MODE, {7'd0, mode});
        write_cfg(ipv6opt_pkg::CFG_WANTED_TYPE, want);
        calm_run = calm;
        start = queued_items;
        if (with_big) begin
            queue_header(39, 255, 1'b0);
        end
        while (queued_items - start < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                units = 0;
            end else if (r < 88) begin
                units = 1;
            end else if (r < 97) begin
                units = $urandom_range(2, 3);
            end else begin
                units = $urandom_range(4, 12);
            end
            queue_header(units, ($urandom_range(0, 99) < 85) ? 6 : 255, 1'b1);
        end
        wait_idle();
    endtask

    // Input driver: present one header byte per word, with random gaps.
    always @(posedge i_clk) begin
        int        gap_left;
        t_hdr_byte item;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && o_ready) begin
                walk_option_byte(i_data_byte, i_end_of_buffer);
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (header_bytes_q.size() != 0) begin
                    item = header_bytes_q.pop_front();
                    i_data_byte     <= item.data;
                    i_end_of_buffer <= item.last;
                    i_valid         <= 1'b1;
                    gap_left = (calm_run || $urandom_range(0, 99) < 65) ? 0 : pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and field-by-field comparison.
    always @(posedge i_clk) begin
        int             stall_left;
        t_option_report got;
        t_option_report want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && i_ready) begin
                got = '{status: o_status, opt_type: o_option_type, opt_len: o_option_length,
                        opt_off: o_option_offset, fin: o_final_result};
                if (pending_reports_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected result word: st=%0d type=%0h len=%0d off=%0d fin=%0d",
                                 got.status, got.opt_type, got.opt_len, got.opt_off, got.fin);
                    end
                end else begin
                    want = pending_reports_q.pop_front();
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("mismatch: expected st=%0d type=%0h len=%0d off=%0d fin=%0d",
                                     want.status, want.opt_type, want.opt_len, want.opt_off,
                                     want.fin);
                            $display("          actual   st=%0d type=%0h len=%0d off=%0d fin=%0d",
                                     got.status, got.opt_type, got.opt_len, got.opt_off, got.fin);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!calm_run && $urandom_range(0, 99) < 20) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Main sequence: directed headers, then random phases over several settings.
    initial begin : stimulus
        // Bit 8 marks the last byte of a buffer.
        logic [8:0] directed_seq[26] = '{
            // Full option with all-ones data ending at the header end.
            9'h03A, 9'h000, 9'h0FF, 9'h004, 9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
            // Length byte that overruns the header, then a trailing byte.
            9'h000, 9'h000, 9'h005, 9'h005, 9'h100,
            // Empty PADN, PAD1s, then a type byte on the header's last offset.
            9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h000, 9'h000, 9'h107,
            // Buffer ends on its first byte.
            9'h1FF,
            // Option report and short buffer on the same byte.
            9'h000, 9'h001, 9'h005, 9'h100
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_cfg(ipv6opt_pkg::CFG_SEARCH_MODE, 8'd0);
        write_cfg(ipv6opt_pkg::CFG_WANTED_TYPE, 8'd0);
        foreach (directed_seq[i]) begin
            queue_byte(directed_seq[i][7:0], directed_seq[i][8]);
        end
        wait_idle();
        run_phase(1'b0, 8'd0, 1'b0, 80, 1'b0);
        run_phase(1'b1, 8'd0, 1'b0, 75, 1'b0);
        run_phase(1'b1, 8'd1, 1'b1, 75, 1'b0);
        run_phase(1'b1, 8'hFF, 1'b0, 75, 1'b0);
        run_phase(1'b1, 8'($urandom_range(2, 254)), 1'b0, 75, 1'b0);
        run_phase(1'b0, 8'hFF, 1'b0, 330, 1'b1);
        run_phase(1'b0, 8'($urandom_range(0, 255)), 1'b0, 70, 1'b0);
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
